@@ rtl/core/wrr_pkg.sv @@
package wrr_pkg;

    localparam int DEPTH       = 16;
    localparam int TAG_BITS    = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int PTR_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_GET_NEXT    = 2'd0,
        REQ_ADD         = 2'd1,
        REQ_REMOVE      = 2'd2,
        REQ_GET_CURRENT = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [TAG_BITS-1:0]    new_data;
        logic [WEIGHT_BITS-1:0] new_weight;
        logic [PTR_BITS-1:0]    remove_index;
    } req_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] served_data;
        logic                data_valid;
        status_t             status;
        logic [CNT_BITS-1:0] entry_count;
    } res_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]    tag;
        logic [WEIGHT_BITS-1:0] weight;
    } entry_t;

endpackage

@@ rtl/core/wrr_ifs.sv @@
interface wrr_req_if;
    import wrr_pkg::*;

    logic                   valid;
    logic                   ready;
    req_type_t              req_type;
    logic [TAG_BITS-1:0]    new_data;
    logic [WEIGHT_BITS-1:0] new_weight;
    logic [PTR_BITS-1:0]    remove_index;

    modport source (output valid, output req_type, output new_data, output new_weight,
                     output remove_index, input ready);
    modport sink (input valid, input req_type, input new_data, input new_weight,
                  input remove_index, output ready);
endinterface

interface wrr_res_if;
    import wrr_pkg::*;

    logic                valid;
    logic                ready;
    logic [TAG_BITS-1:0] served_data;
    logic                data_valid;
    status_t             status;
    logic [CNT_BITS-1:0] entry_count;

    modport source (output valid, output served_data, output data_valid, output status,
                     output entry_count, input ready);
    modport sink (input valid, input served_data, input data_valid, input status,
                  input entry_count, output ready);
endinterface

@@ rtl/core/weighted_round_robin_ring.sv @@
// Channel  Dir  Payload                                              Accepted when
// req      in   req_type, new_data, new_weight, remove_index         req.valid && req.ready
// rsp      out  served_data, data_valid, status, entry_count         rsp.valid && rsp.ready
//
// A get_next or get_current walks over the zero-weight entries (at most the entry count) before
// its result, one RAM read per cycle. An add writes the entry RAM once; a remove moves every entry
// after the removed one down by one slot, with a read and a write of the entry RAM for each moved
// entry. Errors go straight to the result.
// Reset is asynchronous and active low; the entry RAM is not cleared and needs no sweep.
// One item is worked on at a time; the next is taken while its result waits in the output register.
module weighted_round_robin_ring (
    input logic      clk,
    input logic      rst_n,
    wrr_req_if.sink  req,
    wrr_res_if.source rsp
);
    import wrr_pkg::*;

    req_t eng_req;
    res_t eng_res;
    logic eng_res_valid;
    logic eng_res_ready;
    logic out_valid_reg;
    res_t out_res_reg;

    assign eng_req.req_type     = req.req_type;
    assign eng_req.new_data     = req.new_data;
    assign eng_req.new_weight   = req.new_weight;
    assign eng_req.remove_index = req.remove_index;

    wrr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (eng_req),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .res       (eng_res),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready)
    );

    assign eng_res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_res_ready)
        begin
            out_valid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_ready && eng_res_valid)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.served_data = out_res_reg.served_data;
    assign rsp.data_valid  = out_res_reg.data_valid;
    assign rsp.status      = out_res_reg.status;
    assign rsp.entry_count = out_res_reg.entry_count;

endmodule

@@ rtl/core/wrr_engine.sv @@
module wrr_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  wrr_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_ready,
    output wrr_pkg::res_t res,
    output logic          res_valid,
    input  logic          res_ready
);
    import wrr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_RM_RD,
        S_RM_MOVE,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    req_type_t              op_reg, op_next;
    logic [PTR_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    used_reg, used_next;
    logic [PTR_BITS-1:0]    pos_reg, pos_next;
    logic [WEIGHT_BITS-1:0] sc_reg, sc_next;
    logic [TAG_BITS-1:0]    last_tag_reg, last_tag_next;
    logic                   last_valid_reg, last_valid_next;
    logic [CNT_BITS-1:0]    steps_reg, steps_next;
    logic [CNT_BITS-1:0]    sh_reg, sh_next;
    logic [TAG_BITS-1:0]    res_data_reg, res_data_next;
    logic                   res_dv_reg, res_dv_next;
    status_t                res_status_reg, res_status_next;

    entry_t                 mem [DEPTH];
    entry_t                 rd_q;
    logic                   rd_en;
    logic [PTR_BITS-1:0]    rd_addr;
    logic                   wr_en;
    logic [PTR_BITS-1:0]    wr_addr;
    entry_t                 wr_data;

    logic [PTR_BITS-1:0]    pos_adv;
    logic [WEIGHT_BITS-1:0] sc_inc;
    logic [CNT_BITS-1:0]    used_dec;
    logic [CNT_BITS-1:0]    sh_dec;

    function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] p,
                                                    input logic [CNT_BITS-1:0] n);
        logic [CNT_BITS-1:0] q;
        begin
            q = CNT_BITS'(p) + CNT_BITS'(1);
            if (q >= n)
            begin
                advance = '0;
            end
            else
            begin
                advance = q[PTR_BITS-1:0];
            end
        end
    endfunction

    // The entry store is a single-port-write, single-port-read RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    assign pos_adv  = advance(pos_reg, used_reg);
    assign sc_inc   = (sc_reg == '1) ? sc_reg : sc_reg + WEIGHT_BITS'(1);
    assign used_dec = used_reg - CNT_BITS'(1);
    assign sh_dec   = sh_reg - CNT_BITS'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res.served_data = res_data_reg;
    assign res.data_valid  = res_dv_reg;
    assign res.status      = res_status_reg;
    assign res.entry_count = used_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        pos_next        = pos_reg;
        sc_next         = sc_reg;
        last_tag_next   = last_tag_reg;
        last_valid_next = last_valid_reg;
        steps_next      = steps_reg;
        sh_next         = sh_reg;
        res_data_next   = res_data_reg;
        res_dv_next     = res_dv_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_reg;
        wr_en           = 1'b0;
        wr_addr         = used_reg[PTR_BITS-1:0];
        wr_data         = '{tag: req.new_data, weight: req.new_weight};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = req.req_type;
                    res_data_next   = '0;
                    res_dv_next     = 1'b0;
                    res_status_next = ST_OK;
                    case (req.req_type)
                        REQ_GET_NEXT:
                        begin
                            if (used_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SKIP_RD;
                            end
                        end
                        REQ_ADD:
                        begin
                            if (used_reg >= CNT_BITS'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                used_next = used_reg + CNT_BITS'(1);
                            end
                            state_next = S_RESP;
                        end
                        REQ_REMOVE:
                        begin
                            if (used_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else if (CNT_BITS'(req.remove_index) >= used_reg)
                            begin
                                res_status_next = ST_BAD_INDEX;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                idx_next   = req.remove_index;
                                sh_next    = CNT_BITS'(req.remove_index) + CNT_BITS'(1);
                                state_next = S_RM_RD;
                            end
                        end
                        REQ_GET_CURRENT:
                        begin
                            res_data_next = last_tag_reg;
                            res_dv_next   = last_valid_reg;
                            if (used_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SKIP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SKIP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                steps_next = '0;
                state_next = S_SKIP_CHK;
            end
            S_SKIP_CHK:
            begin
                // Walk past zero-weight entries; the read for the next position overlaps the check.
                if (steps_reg < used_reg && rd_q.weight == '0)
                begin
                    sc_next    = '0;
                    pos_next   = pos_adv;
                    rd_en      = 1'b1;
                    rd_addr    = pos_adv;
                    steps_next = steps_reg + CNT_BITS'(1);
                end
                else
                begin
                    if (op_reg == REQ_GET_NEXT)
                    begin
                        last_tag_next   = rd_q.tag;
                        last_valid_next = 1'b1;
                        res_data_next   = rd_q.tag;
                        res_dv_next     = 1'b1;
                        if (rd_q.weight != '0 && sc_inc >= rd_q.weight)
                        begin
                            sc_next  = '0;
                            pos_next = pos_adv;
                        end
                        else
                        begin
                            sc_next = sc_inc;
                        end
                    end
                    else
                    begin
                        res_data_next = last_tag_reg;
                        res_dv_next   = last_valid_reg;
                    end
                    state_next = S_RESP;
                end
            end
            S_RM_RD:
            begin
                if (sh_reg < used_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sh_reg[PTR_BITS-1:0];
                    state_next = S_RM_MOVE;
                end
                else
                begin
                    used_next = used_dec;
                    if (pos_reg == idx_reg)
                    begin
                        sc_next = '0;
                        if (CNT_BITS'(pos_reg) >= used_dec)
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (pos_reg > idx_reg)
                    begin
                        pos_next = pos_reg - PTR_BITS'(1);
                    end
                    if (used_dec == '0)
                    begin
                        pos_next = '0;
                    end
                    state_next = S_RESP;
                end
            end
            S_RM_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = sh_dec[PTR_BITS-1:0];
                wr_data    = rd_q;
                sh_next    = sh_reg + CNT_BITS'(1);
                state_next = S_RM_RD;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= REQ_GET_NEXT;
            used_reg       <= '0;
            pos_reg        <= '0;
            sc_reg         <= '0;
            last_tag_reg   <= '0;
            last_valid_reg <= 1'b0;
            steps_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            used_reg       <= used_next;
            pos_reg        <= pos_next;
            sc_reg         <= sc_next;
            last_tag_reg   <= last_tag_next;
            last_valid_reg <= last_valid_next;
            steps_reg      <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        sh_reg         <= sh_next;
        res_data_reg   <= res_data_next;
        res_dv_reg     <= res_dv_next;
        res_status_reg <= res_status_next;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_BITS'(DEPTH))
        else $error("entry count exceeds table depth");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 |-> CNT_BITS'(pos_reg) < used_reg)
        else $error("position points past the last entry");

    a_pos_empty: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == '0 |-> pos_reg == '0)
        else $error("position not zero on an empty table");

    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != S_IDLE)
        else $error("accepted item produced no work");

    a_last_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        last_valid_reg |=> last_valid_reg)
        else $error("last served tag lost its valid flag");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SKIP_CHK |-> steps_reg <= used_reg)
        else $error("skip walk ran past one lap");
`endif

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wrr_pkg::*;

    localparam int QUIET_TAIL = 200;
    localparam int END_WAIT   = 40;

    logic clk;
    logic rst_n;

    wrr_req_if req_ch ();
    wrr_res_if rsp_ch ();

    weighted_round_robin_ring i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Own copy of the ring state, updated as each item is accepted.
    logic [TAG_BITS-1:0]    ring_tag [DEPTH];
    logic [WEIGHT_BITS-1:0] ring_wgt [DEPTH];
    int unsigned            ring_cnt;
    int unsigned            ring_pos;
    int unsigned            ring_serves;
    logic [TAG_BITS-1:0]    last_served;
    logic                   last_served_ok;

    req_t request_q [$];
    res_t pending_responses [$];

    int  error_count;
    int  gen_cnt;
    bit  req_fire;
    int  req_gap;
    int  rsp_stall;
    int  idle_rate;
    int  cycle_no;

    always #5 clk = ~clk;

    function automatic void step_position();
        ring_pos++;
        if (ring_pos >= ring_cnt || ring_pos >= DEPTH)
        begin
            ring_pos = 0;
        end
    endfunction

    function automatic void skip_idle_entries();
        int unsigned steps;
        steps = 0;
        if (ring_pos >= DEPTH)
        begin
            ring_pos = 0;
        end
        while (steps < ring_cnt && ring_wgt[ring_pos] == '0)
        begin
            steps++;
            ring_serves = 0;
            step_position();
        end
    endfunction

    function automatic res_t predict_response(req_t rq);
        res_t rs;
        int unsigned idx;
        rs.served_data = '0;
        rs.data_valid  = 1'b0;
        rs.status      = ST_OK;
        idx = rq.remove_index;
        case (rq.req_type)
            REQ_GET_NEXT:
            begin
                if (ring_cnt == 0)
                begin
                    rs.status = ST_EMPTY;
                end
                else
                begin
                    skip_idle_entries();
                    last_served    = ring_tag[ring_pos];
                    last_served_ok = 1'b1;
                    rs.served_data = last_served;
                    rs.data_valid  = 1'b1;
                    if (ring_serves < (1 << WEIGHT_BITS) - 1)
                    begin
                        ring_serves++;
                    end
                    if (ring_wgt[ring_pos] != '0 && ring_serves >= ring_wgt[ring_pos])
                    begin
                        ring_serves = 0;
                        step_position();
                    end
                end
            end
            REQ_ADD:
            begin
                if (ring_cnt >= DEPTH)
                begin
                    rs.status = ST_FULL;
                end
                else
                begin
                    ring_tag[ring_cnt] = rq.new_data;
                    ring_wgt[ring_cnt] = rq.new_weight;
                    ring_cnt++;
                end
            end
            REQ_REMOVE:
            begin
                if (ring_cnt == 0)
                begin
                    rs.status = ST_EMPTY;
                end
                else if (idx >= ring_cnt)
                begin
                    rs.status = ST_BAD_INDEX;
                end
                else
                begin
                    for (int i = idx + 1; i < ring_cnt; i++)
                    begin
                        ring_tag[i-1] = ring_tag[i];
                        ring_wgt[i-1] = ring_wgt[i];
                    end
                    ring_cnt--;
                    if (ring_pos == idx)
                    begin
                        ring_serves = 0;
                        if (ring_pos >= ring_cnt)
                        begin
                            ring_pos = 0;
                        end
                    end
                    else if (ring_pos > idx)
                    begin
                        ring_pos--;
                    end
                    if (ring_cnt == 0)
                    begin
                        ring_pos = 0;
                    end
                end
            end
            default:
            begin
                if (ring_cnt == 0)
                begin
                    rs.status = ST_EMPTY;
                end
                else
                begin
                    skip_idle_entries();
                end
                rs.served_data = last_served;
                rs.data_valid  = last_served_ok;
            end
        endcase
        rs.entry_count = CNT_BITS'(ring_cnt);
        return rs;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            return '0;
        end
        else if (sel < 8)
        begin
            return WEIGHT_BITS'($urandom_range(1, 4));
        end
        else if (sel == 8)
        begin
            return WEIGHT_BITS'($urandom_range(5, 20));
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            return '1;
        end
        return WEIGHT_BITS'($urandom);
    endfunction

    task automatic queue_req(req_type_t k, logic [TAG_BITS-1:0] d,
                             logic [WEIGHT_BITS-1:0] w, logic [PTR_BITS-1:0] ix);
        req_t r;
        r.req_type     = k;
        r.new_data     = d;
        r.new_weight   = w;
        r.remove_index = ix;
        request_q.push_back(r);
        if (k == REQ_ADD && gen_cnt < DEPTH)
        begin
            gen_cnt++;
        end
        else if (k == REQ_REMOVE && gen_cnt > 0 && ix < gen_cnt)
        begin
            gen_cnt--;
        end
    endtask

    task automatic queue_noise(req_type_t k);
        queue_req(k, TAG_BITS'($urandom), WEIGHT_BITS'($urandom), PTR_BITS'($urandom));
    endtask

    task automatic queue_remove_inside();
        if (gen_cnt > 0 && $urandom_range(0, 4) != 0)
        begin
            queue_req(REQ_REMOVE, TAG_BITS'($urandom), WEIGHT_BITS'($urandom),
                      PTR_BITS'($urandom_range(0, gen_cnt - 1)));
        end
        else
        begin
            queue_noise(REQ_REMOVE);
        end
    endtask

    task automatic queue_add();
        queue_req(REQ_ADD, TAG_BITS'($urandom), pick_weight(), PTR_BITS'($urandom));
    endtask

    // Driver: requests change at the falling edge, with random idle bursts.
    always @(negedge clk)
    begin : req_driver
        logic next_valid;
        req_t next_item;
        cycle_no++;
        if (cycle_no % 200 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       idle_rate = 0;
                1:       idle_rate = 10;
                default: idle_rate = 30;
            endcase
        end
        if (request_q.size() < QUIET_TAIL)
        begin
            idle_rate = 0;
        end
        if (rst_n && (!req_ch.valid || req_fire))
        begin
            next_valid = 1'b0;
            if (req_gap > 0)
            begin
                req_gap--;
            end
            else if (request_q.size() != 0)
            begin
                next_item  = request_q.pop_front();
                next_valid = 1'b1;
                req_ch.req_type     <= next_item.req_type;
                req_ch.new_data     <= next_item.new_data;
                req_ch.new_weight   <= next_item.new_weight;
                req_ch.remove_index <= next_item.remove_index;
                if ($urandom_range(0, 99) < idle_rate)
                begin
                    req_gap = $urandom_range(1, 4);
                end
            end
            req_ch.valid <= next_valid;
        end
        if (rst_n)
        begin
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < idle_rate)
                begin
                    rsp_stall = $urandom_range(1, 4);
                end
            end
        end
    end

    // Monitor: both channels are sampled at the rising edge.
    always @(posedge clk)
    begin : channel_monitor
        req_t acc;
        res_t want;
        req_fire = rst_n && req_ch.valid && req_ch.ready;
        if (req_fire)
        begin
            acc.req_type     = req_ch.req_type;
            acc.new_data     = req_ch.new_data;
            acc.new_weight   = req_ch.new_weight;
            acc.remove_index = req_ch.remove_index;
            pending_responses.push_back(predict_response(acc));
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected item: served_data %h data_valid %b status %0d count %0d",
                         $time, rsp_ch.served_data, rsp_ch.data_valid, rsp_ch.status,
                         rsp_ch.entry_count);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (rsp_ch.served_data !== want.served_data)
                begin
                    error_count++;
                    $display("%0t: served_data expected %h actual %h",
                             $time, want.served_data, rsp_ch.served_data);
                end
                if (rsp_ch.data_valid !== want.data_valid)
                begin
                    error_count++;
                    $display("%0t: data_valid expected %b actual %b",
                             $time, want.data_valid, rsp_ch.data_valid);
                end
                if (rsp_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    error_count++;
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, rsp_ch.entry_count);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int mode;
        int burst;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_GET_NEXT;
        req_ch.new_data     = '0;
        req_ch.new_weight   = '0;
        req_ch.remove_index = '0;
        rsp_ch.ready        = 1'b0;
        error_count         = 0;
        gen_cnt             = 0;
        req_fire            = 1'b0;
        req_gap             = 0;
        rsp_stall           = 0;
        idle_rate           = 10;
        cycle_no            = 0;
        ring_cnt            = 0;
        ring_pos            = 0;
        ring_serves         = 0;
        last_served         = '0;
        last_served_ok      = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_tag[i] = '0;
            ring_wgt[i] = '0;
        end

        // Empty table, then single zero-weight entry, a heavy entry and removals.
        queue_noise(REQ_GET_NEXT);
        queue_noise(REQ_GET_CURRENT);
        queue_req(REQ_REMOVE, '0, '0, 4'd15);
        queue_req(REQ_REMOVE, '1, '1, 4'd0);
        queue_req(REQ_ADD, 16'hFFFF, 16'h0000, 4'd15);
        queue_noise(REQ_GET_NEXT);
        queue_noise(REQ_GET_NEXT);
        queue_noise(REQ_GET_CURRENT);
        queue_req(REQ_ADD, 16'h0000, 16'hFFFF, 4'd0);
        queue_noise(REQ_GET_NEXT);
        queue_noise(REQ_GET_NEXT);
        queue_req(REQ_ADD, 16'h1234, 16'd1, 4'd0);
        queue_req(REQ_ADD, 16'h0001, 16'd2, 4'd0);
        queue_req(REQ_REMOVE, '0, '0, 4'd15);
        queue_req(REQ_REMOVE, '0, '0, 4'd4);
        queue_req(REQ_REMOVE, '0, '0, 4'd1);
        queue_noise(REQ_GET_NEXT);
        queue_noise(REQ_GET_NEXT);
        queue_req(REQ_REMOVE, '0, '0, 4'd0);
        queue_noise(REQ_GET_CURRENT);
        queue_noise(REQ_GET_NEXT);
        queue_req(REQ_REMOVE, '0, '0, 4'd1);
        queue_noise(REQ_GET_CURRENT);

        n = request_q.size();
        while (n < 1350)
        begin
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2:
                begin
                    burst = $urandom_range(1, 6);
                    repeat (burst) queue_add();
                end
                3, 4, 5:
                begin
                    burst = $urandom_range(5, 20);
                    repeat (burst)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            queue_noise(REQ_GET_CURRENT);
                        end
                        else
                        begin
                            queue_noise(REQ_GET_NEXT);
                        end
                    end
                end
                6, 7:
                begin
                    burst = $urandom_range(1, 3);
                    repeat (burst) queue_remove_inside();
                end
                8:
                begin
                    while (gen_cnt < DEPTH)
                    begin
                        queue_add();
                    end
                    burst = $urandom_range(1, 2);
                    repeat (burst) queue_add();
                    repeat (4) queue_noise(REQ_GET_NEXT);
                    queue_req(REQ_REMOVE, '0, '0, 4'd15);
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        while (gen_cnt > 0)
                        begin
                            queue_req(REQ_REMOVE, TAG_BITS'($urandom), WEIGHT_BITS'($urandom),
                                      PTR_BITS'($urandom_range(0, gen_cnt - 1)));
                        end
                        queue_noise(REQ_GET_NEXT);
                        queue_noise(REQ_GET_CURRENT);
                        queue_noise(REQ_REMOVE);
                    end
                    else
                    begin
                        queue_noise(req_type_t'($urandom_range(0, 3)));
                    end
                end
            endcase
            n = request_q.size();
        end

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (pending_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0 && pending_responses.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
